[rtl/core/fgr_pkg.sv]
// Shared types, register indexes and the 5x7 font table for the character generator.
package fgr_pkg;

    localparam int CellW  = 6;
    localparam int CellH  = 8;
    localparam int GlyphW = 5;
    localparam int GlyphH = 7;

    localparam logic [7:0] GlyphFirst = 8'd32;
    localparam logic [7:0] GlyphLast  = 8'd90;
    localparam logic [7:0] LowerFirst = 8'h61;
    localparam logic [7:0] LowerLast  = 8'h7A;
    localparam logic [7:0] CaseOffset = 8'h20;

    localparam logic [15:0] CellStep = 16'd6;

    localparam logic [15:0] FgReset = 16'hFFFF;
    localparam logic [15:0] BgReset = 16'h0000;

    // configuration register indexes
    localparam logic [7:0] CFG_FG_COLOR = 8'd0;
    localparam logic [7:0] CFG_BG_COLOR = 8'd1;

    // one classified character handed from front to back
    typedef struct packed {
        logic [5:0]  glyph;
        logic [15:0] left;
        logic [15:0] top;
    } t_fgr_cmd;

    // fold lower case, map anything outside the font to space, return ROM row
    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] c;
        logic [7:0] d;
        c = code;
        if (c inside {[LowerFirst:LowerLast]}) begin
            c = c - CaseOffset;
        end
        if (!(c inside {[GlyphFirst:GlyphLast]})) begin
            c = GlyphFirst;
        end
        d = c - GlyphFirst;
        return d[5:0];
    endfunction

    // five column bytes, column 0 in the top byte; bit r of a byte is row r
    function automatic logic [39:0] font_cols(input logic [5:0] idx);
        logic [39:0] f;
        case (idx)
            6'd0:  f = 40'h0000000000;
            6'd1:  f = 40'h00005F0000;
            6'd2:  f = 40'h0007000700;
            6'd3:  f = 40'h147F147F14;
            6'd4:  f = 40'h242A7F2A12;
            6'd5:  f = 40'h2313086462;
            6'd6:  f = 40'h3649552250;
            6'd7:  f = 40'h0005030000;
            6'd8:  f = 40'h001C224100;
            6'd9:  f = 40'h0041221C00;
            6'd10: f = 40'h14083E0814;
            6'd11: f = 40'h08083E0808;
            6'd12: f = 40'h0050300000;
            6'd13: f = 40'h0808080808;
            6'd14: f = 40'h0060600000;
            6'd15: f = 40'h2010080402;
            6'd16: f = 40'h3E5149453E;
            6'd17: f = 40'h00427F4000;
            6'd18: f = 40'h4261514946;
            6'd19: f = 40'h2141454B31;
            6'd20: f = 40'h1814127F10;
            6'd21: f = 40'h2745454539;
            6'd22: f = 40'h3C4A494930;
            6'd23: f = 40'h0171090503;
            6'd24: f = 40'h3649494936;
            6'd25: f = 40'h064949291E;
            6'd26: f = 40'h0036360000;
            6'd27: f = 40'h0056360000;
            6'd28: f = 40'h0814224100;
            6'd29: f = 40'h1414141414;
            6'd30: f = 40'h0041221408;
            6'd31: f = 40'h0201510906;
            6'd32: f = 40'h324979413E;
            6'd33: f = 40'h7E1111117E;
            6'd34: f = 40'h7F49494936;
            6'd35: f = 40'h3E41414122;
            6'd36: f = 40'h7F4141221C;
            6'd37: f = 40'h7F49494941;
            6'd38: f = 40'h7F09090901;
            6'd39: f = 40'h3E4149497A;
            6'd40: f = 40'h7F0808087F;
            6'd41: f = 40'h00417F4100;
            6'd42: f = 40'h2040413F01;
            6'd43: f = 40'h7F08142241;
            6'd44: f = 40'h7F40404040;
            6'd45: f = 40'h7F020C027F;
            6'd46: f = 40'h7F0408107F;
            6'd47: f = 40'h3E4141413E;
            6'd48: f = 40'h7F09090906;
            6'd49: f = 40'h3E4151215E;
            6'd50: f = 40'h7F09192946;
            6'd51: f = 40'h4649494931;
            6'd52: f = 40'h01017F0101;
            6'd53: f = 40'h3F4040403F;
            6'd54: f = 40'h1F2040201F;
            6'd55: f = 40'h3F4038403F;
            6'd56: f = 40'h6314081463;
            6'd57: f = 40'h0708700807;
            6'd58: f = 40'h6151494543;
            default: f = 40'h0000000000;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/fgr_front.sv]
// Front end: takes characters, resolves glyph and cell position, tracks the cursor.
module fgr_front
    import fgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    input  logic       i_restart,
    input  logic [8:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_fgr_cmd   o_cmd
);

    logic [15:0] r_cursor_x;
    logic [15:0] r_cursor_y;
    logic [15:0] n_left;
    logic [15:0] n_top;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        if (i_restart) begin
            n_left = {7'd0, i_pos_x};
            n_top  = {8'd0, i_pos_y};
        end else begin
            n_left = r_cursor_x;
            n_top  = r_cursor_y;
        end
    end

    assign o_cmd.glyph = glyph_index(i_char_code);
    assign o_cmd.left  = n_left;
    assign o_cmd.top   = n_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else if (o_push) begin
            r_cursor_x <= n_left + CellStep;
            r_cursor_y <= n_top;
        end
    end

endmodule

[rtl/core/fgr_queue.sv]
// Small FIFO of classified characters between front and back.
module fgr_queue
    import fgr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fgr_cmd i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_fgr_cmd o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_fgr_cmd        r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            n_push;
    logic            n_pop;

    assign o_full  = (r_count == CntFull);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/fgr_back.sv]
// Back end: walks the 6x8 cell of one glyph and emits one pixel per cycle unless the output stalls.
module fgr_back
    import fgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_fgr_cmd    i_q_data,
    output logic        o_q_pop,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel_x,
    output logic [15:0] o_pixel_y,
    output logic [15:0] o_color,
    output logic        o_last
);

    localparam logic [2:0] ColLast  = 3'(CellW - 1);
    localparam logic [2:0] RowLast  = 3'(CellH - 1);
    localparam logic [2:0] GlyphCols = 3'(GlyphW);
    localparam logic [2:0] GlyphRows = 3'(GlyphH);

    logic [15:0] r_fg;
    logic [15:0] r_bg;
    logic        r_busy;
    logic [39:0] r_glyph;
    logic [15:0] r_left;
    logic [15:0] r_top;
    logic [2:0]  r_col;
    logic [2:0]  r_row;
    logic        r_out_valid;
    logic [15:0] r_out_x;
    logic [15:0] r_out_y;
    logic [15:0] r_out_color;
    logic        r_out_last;

    logic        n_adv;
    logic        n_pix_go;
    logic        n_is_last;
    logic [7:0]  n_col_byte;
    logic        n_on;

    assign n_adv     = !r_out_valid || i_ready;
    assign n_pix_go  = r_busy && n_adv;
    assign n_is_last = (r_row == RowLast) && (r_col == ColLast);
    assign o_q_pop   = i_q_valid && (!r_busy || (n_pix_go && n_is_last));

    always_comb begin
        case (r_col)
            3'd0:    n_col_byte = r_glyph[39:32];
            3'd1:    n_col_byte = r_glyph[31:24];
            3'd2:    n_col_byte = r_glyph[23:16];
            3'd3:    n_col_byte = r_glyph[15:8];
            3'd4:    n_col_byte = r_glyph[7:0];
            default: n_col_byte = 8'd0;
        endcase
        n_on = (r_col < GlyphCols) && (r_row < GlyphRows) && n_col_byte[r_row];
    end

    // color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FgReset;
            r_bg <= BgReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FG_COLOR) begin
                r_fg <= i_cfg_data;
            end else if (i_cfg_index == CFG_BG_COLOR) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_col  <= '0;
                r_row  <= '0;
            end else if (n_pix_go) begin
                if (n_is_last) begin
                    r_busy <= 1'b0;
                end
                if (r_col == ColLast) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (n_adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_glyph <= font_cols(i_q_data.glyph);
            r_left  <= i_q_data.left;
            r_top   <= i_q_data.top;
        end
        if (n_pix_go) begin
            r_out_x     <= r_left + {13'd0, r_col};
            r_out_y     <= r_top + {13'd0, r_row};
            r_out_color <= n_on ? r_fg : r_bg;
            r_out_last  <= n_is_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_color   = r_out_color;
    assign o_last    = r_out_last;

    a_pop_restarts_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_busy && r_col == '0 && r_row == '0))
        else $error("cell walk did not restart on a new glyph");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_pix_go && n_is_last && !i_q_valid) |=> !r_busy)
        else $error("back end stayed busy past the last pixel");

    a_col_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_col <= ColLast))
        else $error("column counter left the cell");

    a_last_on_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_pix_go && n_is_last) |=> (r_out_valid && r_out_last))
        else $error("last pixel not flagged");

endmodule

[rtl/core/font_glyph_rasterizer_5x7_top.sv]
// Top level of the 5x7 character generator: front end, command queue and pixel back end.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: char_code[7:0] pos_x[16:8] pos_y[24:17]; tuser: restart
//  m_axis    | out       | tdata: pixel_x[15:0] pixel_y[31:16] color[47:32]; tlast: last
//  cfg       | in        | i_cfg_index (0 fg_color, 1 bg_color), i_cfg_data[15:0]
//
// Each character produces 48 pixels, one per cycle while m_axis is not stalled;
// successive cells follow with no gap when the next character is already queued.
// A character passes the queue, then the cell registers and the output pixel register.
// Reset is synchronous, active low: cursor at 0,0, fg_color 0xFFFF, bg_color 0x0000.
// A stall on m_axis holds the pixel walk; the queue keeps taking characters until full.
module font_glyph_rasterizer_5x7_top
    import fgr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code[7:0], pos_x[16:8], pos_y[24:17], zero
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pixel_x[15:0], pixel_y[31:16], color[47:32]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_fgr_cmd    w_push_cmd;
    t_fgr_cmd    w_pop_cmd;
    logic        w_push;
    logic        w_pop;
    logic        w_q_full;
    logic        w_q_valid;
    logic [15:0] w_pixel_x;
    logic [15:0] w_pixel_y;
    logic [15:0] w_color;

    assign o_cfg_ready = 1'b1;

    fgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_char_code (s_axis_tdata[7:0]),
        .i_restart   (s_axis_tuser),
        .i_pos_x     (s_axis_tdata[16:8]),
        .i_pos_y     (s_axis_tdata[24:17]),
        .i_q_full    (w_q_full),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    fgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_pop_cmd)
    );

    fgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_pop_cmd),
        .o_q_pop     (w_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pixel_x   (w_pixel_x),
        .o_pixel_y   (w_pixel_y),
        .o_color     (w_color),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {w_color, w_pixel_y, w_pixel_x};

endmodule
